// ----- rtl/tpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared types, codes and constants of the touch press classifier.
// ----------------------------------------------------------------------------
package tpc_pkg;

    // Calibration settings
    localparam int CAL_SAMPLES     = 4;
    localparam int UNTOUCHED_LIMIT = 40;
    localparam int CAL_LIMIT       = UNTOUCHED_LIMIT * CAL_SAMPLES;
    localparam int CAL_LIMIT_W     = 12;
    // Sum / CAL_SAMPLES by reciprocal multiply, exact for 8-bit sums
    localparam int CAL_RECIP_SHIFT = 16;
    localparam int CAL_RECIP       = ((2 ** CAL_RECIP_SHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES;
    localparam int CAL_RECIP_W     = CAL_RECIP_SHIFT + 1;

    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 16;
    localparam int SUM_W    = 8;
    localparam int THRESH_W = 7;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 7'd14;
    localparam logic [THRESH_W-1:0] THRESH_MAX   = 7'd127;

    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd500;
    localparam logic [CFG_W-1:0] MIN_PRESS_RESET  = 16'd50;
    localparam logic [CFG_W-1:0] GAP_RESET        = 16'd1500;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PRESS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP        = 2'd2;

    typedef enum logic {
        CMD_POLL = 1'b0,
        CMD_CAL  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_DOWN   = 2'd1,
        PH_ASSERT = 2'd2,
        PH_WAIT   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        RES_NONE  = 2'd0,
        RES_SHORT = 2'd1,
        RES_LONG  = 2'd2
    } press_res_t;

    typedef struct packed {
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] min_press_ms;
        logic [CFG_W-1:0] gap_ms;
    } press_cfg_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [TIME_W-1:0]   now_ms;
        logic [COUNT_W-1:0]  discharge_count;
        logic [SUM_W-1:0]    cal_sum;
    } poll_item_t;

    typedef struct packed {
        logic                cal_discarded;
        logic [THRESH_W-1:0] threshold_now;
        logic [COUNT_W-1:0]  peak_discharge;
        phase_t              press_phase;
        logic                pad_touched;
        press_res_t          touch_result;
    } press_result_t;

endpackage

// ----- rtl/tpc_press_fsm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_press_fsm
// Press phase machine, peak tracking and threshold calibration for one item.
// ----------------------------------------------------------------------------
module tpc_press_fsm
    import tpc_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          advance,
    input  poll_item_t    item,
    input  press_cfg_t    cfg,
    output press_result_t result
);

    phase_t               phase_reg, phase_next;
    logic [TIME_W-1:0]    event_time_reg, event_time_next;
    logic [THRESH_W-1:0]  thresh_reg, thresh_next;
    logic [COUNT_W-1:0]   peak_reg, peak_next;
    press_res_t           held_reg, held_next;

    logic [TIME_W-1:0]    elapsed;
    logic                 raw_touch;
    logic [COUNT_W-1:0]   peak_max;
    logic                 past_long;
    logic                 past_min;
    logic                 past_gap;
    logic                 cal_sat;
    logic [SUM_W+CAL_RECIP_W-1:0] cal_prod;
    logic [SUM_W-1:0]     cal_quot;
    logic [SUM_W:0]       cal_thresh;
    logic                 touched;
    logic                 discarded;

    assign elapsed   = item.now_ms - event_time_reg;
    assign raw_touch = item.discharge_count > {{(COUNT_W-THRESH_W){1'b0}}, thresh_reg};
    assign peak_max  = (item.discharge_count > peak_reg) ? item.discharge_count : peak_reg;
    assign past_long = elapsed > {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_ms};
    assign past_min  = elapsed > {{(TIME_W-CFG_W){1'b0}}, cfg.min_press_ms};
    assign past_gap  = elapsed > {{(TIME_W-CFG_W){1'b0}}, cfg.gap_ms};

    assign cal_sat    = {{(CAL_LIMIT_W-SUM_W){1'b0}}, item.cal_sum}
                        >= CAL_LIMIT_W'(CAL_LIMIT);
    assign cal_prod   = {{CAL_RECIP_W{1'b0}}, item.cal_sum}
                        * {{SUM_W{1'b0}}, CAL_RECIP_W'(CAL_RECIP)};
    assign cal_quot   = cal_prod[CAL_RECIP_SHIFT +: SUM_W];
    assign cal_thresh = {cal_quot, 1'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            event_time_reg <= '0;
            thresh_reg     <= THRESH_RESET;
            peak_reg       <= '0;
            held_reg       <= RES_NONE;
        end else if (advance) begin
            phase_reg      <= phase_next;
            event_time_reg <= event_time_next;
            thresh_reg     <= thresh_next;
            peak_reg       <= peak_next;
            held_reg       <= held_next;
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        event_time_next = event_time_reg;
        thresh_next     = thresh_reg;
        peak_next       = peak_reg;
        held_next       = held_reg;
        touched         = 1'b0;
        discarded       = 1'b0;

        if (item.cmd == CMD_CAL) begin
            if (cal_sat) begin
                discarded = 1'b1;
            end else if (cal_thresh > {2'b00, THRESH_MAX}) begin
                thresh_next = THRESH_MAX;
            end else begin
                thresh_next = cal_thresh[THRESH_W-1:0];
            end
        end else begin
            touched = raw_touch;
            case (phase_reg)
                PH_IDLE: begin
                    // peak restarts at zero when a press begins
                    peak_next = raw_touch ? '0 : peak_max;
                    if (raw_touch) begin
                        phase_next      = PH_DOWN;
                        event_time_next = item.now_ms;
                    end
                end
                PH_DOWN: begin
                    peak_next = peak_max;
                    if (!raw_touch || past_long) begin
                        if (past_min) begin
                            held_next       = past_long ? RES_LONG : RES_SHORT;
                            phase_next      = PH_ASSERT;
                            event_time_next = item.now_ms;
                        end else begin
                            // too short: drop
                            phase_next = PH_IDLE;
                        end
                    end
                end
                PH_ASSERT: begin
                    if (past_gap) begin
                        held_next  = RES_NONE;
                        phase_next = PH_WAIT;
                    end
                end
                PH_WAIT: begin
                    peak_next = raw_touch ? peak_max : '0;
                    if (!raw_touch) begin
                        phase_next = PH_IDLE;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        result.touch_result   = held_next;
        result.pad_touched    = touched;
        result.press_phase    = phase_next;
        result.peak_discharge = peak_next;
        result.threshold_now  = thresh_next;
        result.cal_discarded  = discarded;
    end

endmodule

// ----- rtl/touch_press_classifier_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_press_classifier_unit
// Short/long press classifier for a capacitive touch pad.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one request per poll or calibration item. s_tuser = cmd
//   (0 poll, 1 calibration); s_tdata carries now_ms, discharge_count, cal_sum.
//   m_ channel: exactly one result per request, in order, carrying the held
//   press report, touch flag, press phase, peak count, threshold and the
//   calibration-discarded flag.
//   cfg_ port: write long_press_ms (0), min_press_ms (1), gap_ms (2) while
//   no request is in flight; other indexes are ignored.
// Path: a request passes through the input register, then through the phase
//   machine into the result register, which drives m_tvalid and m_tdata.
// Throughput: one request per cycle while m_tready is high; the phase
//   machine state is updated in the same cycle that fills the result register.
// Reset: aresetn low clears both channels, puts the phase machine in idle,
//   threshold to 14, peak and report to zero, configuration registers to their defaults.
// Stall: while m_tready is low the result holds; one more request is taken
//   into the input register, then s_tready drops.
// ----------------------------------------------------------------------------
module touch_press_classifier_unit
    import tpc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [55:0]          s_tdata,  // now_ms[31:0], discharge_count[47:32], cal_sum[55:48]
    input  logic                 s_tuser,  // cmd[0]
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata   // touch_result[1:0], pad_touched[2],
                                           // press_phase[4:3], peak_discharge[20:5],
                                           // threshold_now[27:21], cal_discarded[28]
);

    press_cfg_t    cfg_reg;
    logic          in_valid_reg;
    poll_item_t    in_item_reg;
    logic          out_valid_reg;
    press_result_t out_data_reg;
    press_result_t fsm_result;
    logic          out_free;
    logic          advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_press_ms <= LONG_PRESS_RESET;
            cfg_reg.min_press_ms  <= MIN_PRESS_RESET;
            cfg_reg.gap_ms        <= GAP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LONG_PRESS: cfg_reg.long_press_ms <= cfg_data;
                CFG_MIN_PRESS:  cfg_reg.min_press_ms  <= cfg_data;
                CFG_GAP:        cfg_reg.gap_ms        <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.cmd             <= cmd_t'(s_tuser);
            in_item_reg.now_ms          <= s_tdata[31:0];
            in_item_reg.discharge_count <= s_tdata[47:32];
            in_item_reg.cal_sum         <= s_tdata[55:48];
        end
    end

    tpc_press_fsm u_press_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (fsm_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= fsm_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_data_reg.cal_discarded,
                       out_data_reg.threshold_now,
                       out_data_reg.peak_discharge,
                       out_data_reg.press_phase,
                       out_data_reg.pad_touched,
                       out_data_reg.touch_result};

    // A report is held exactly while the phase machine sits in asserted
    a_report_matches_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[4:3] == PH_ASSERT) == (m_tdata[1:0] != RES_NONE)))
        else $error("held report does not match press phase");

    // Calibration and poll flags never appear together
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[28] && m_tdata[2]))
        else $error("cal_discarded and pad_touched both set");

    // An empty result register must never hold off requests
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("request channel stalled with empty result register");

    // A request that leaves the input register reaches the output next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("processed request produced no result");

endmodule
